// ===== src/wiqf_pkg.sv =====
// wiqf_pkg: shared types, codes and widths for the wavetable quadrupole force block
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package wiqf_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int PTS_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int POS_W      = 32;
  localparam int AMP_W      = 16;
  localparam int COEF_W     = 35;
  localparam int FORCE_W    = 48;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_FORCE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A      = 2'd2;

  localparam logic [PTS_W-1:0] POINTS_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [9:0]              load_index;
    logic signed [AMP_W-1:0] load_value;
    logic [31:0]             phase_step;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [AMP_W-1:0]   potential_now;
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic phase_en;
    logic pot_en;
  } wave_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADV1,
    ST_ADV2,
    ST_ADV3,
    ST_ADV4,
    ST_ADV5,
    ST_FRC1,
    ST_FRC2,
    ST_FRC3,
    ST_FRC4,
    ST_DONE
  } state_t;

endpackage

// ===== src/wiqf_wave.sv =====
// wiqf_wave: wave table, phase accumulator and linear interpolation of the potential
// depends on wiqf_pkg
`timescale 1ns / 1ps

module wiqf_wave #(
  parameter int TABLE_DEPTH = wiqf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wiqf_pkg::wave_ctrl_t                ctrl,
  input  logic [9:0]                          load_index,
  input  logic signed [wiqf_pkg::AMP_W-1:0]   load_value,
  input  logic [31:0]                         phase_step,
  input  logic [wiqf_pkg::PTS_W-1:0]          n_eff,
  output logic signed [wiqf_pkg::AMP_W-1:0]   potential
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW    = wiqf_pkg::PTS_W;
  localparam int PROD_W = 32 + PW;

  logic signed [wiqf_pkg::AMP_W-1:0] mem [TABLE_DEPTH];

  logic [31:0]                       phase;
  logic [PROD_W-1:0]                 prod;
  logic [31:0]                       frac;
  logic signed [wiqf_pkg::AMP_W-1:0] rd1;
  logic signed [wiqf_pkg::AMP_W-1:0] rd2;
  logic signed [wiqf_pkg::AMP_W-1:0] v1;
  logic signed [49:0]                dprod;

  logic [PW-1:0]    i1;
  logic [PW:0]      i1_inc;
  logic [PW-1:0]    i2;
  logic signed [16:0] diff;
  logic signed [17:0] pot_sum;

  // index is the integer part of phase * points, next index wraps at the period end
  assign i1      = prod[PROD_W-1:32];
  assign i1_inc  = {1'b0, i1} + {{PW{1'b0}}, 1'b1};
  assign i2      = (i1_inc >= {1'b0, n_eff}) ? '0 : i1_inc[PW-1:0];
  assign diff    = 17'(rd2) - 17'(rd1);
  assign pot_sum = 18'(v1) + $signed(dprod[49:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      potential <= '0;
    end else begin
      if (ctrl.phase_en) begin
        phase <= phase + phase_step;
      end
      if (ctrl.pot_en) begin
        potential <= pot_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.we && (32'(load_index) < TABLE_DEPTH)) begin
      mem[AW'(load_index)] <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    rd1 <= mem[AW'(i1)];
    rd2 <= mem[AW'(i2)];
  end

  always_ff @(posedge clk) begin
    prod  <= {{PW{1'b0}}, phase} * {32'd0, n_eff};
    frac  <= prod[31:0];
    v1    <= rd1;
    dprod <= 50'(diff) * 50'($signed({1'b0, frac}));
  end

endmodule

// ===== src/wiqf_force_lane.sv =====
// wiqf_force_lane: one axis of the force, pos * coef / 2^16 with 48-bit saturation
// depends on wiqf_pkg
`timescale 1ns / 1ps

module wiqf_force_lane (
  input  logic                                 clk,
  input  logic signed [wiqf_pkg::POS_W-1:0]    pos,
  input  logic signed [wiqf_pkg::COEF_W-1:0]   coef,
  output logic signed [wiqf_pkg::FORCE_W-1:0]  force_out
);

  localparam int CW    = wiqf_pkg::COEF_W;
  localparam int FW    = wiqf_pkg::FORCE_W;
  localparam int HI_W  = wiqf_pkg::POS_W + CW - 16;
  localparam int LO_W  = wiqf_pkg::POS_W + 17;
  localparam int SUM_W = HI_W + 1;

  logic signed [HI_W-1:0]  hi;
  logic signed [LO_W-1:0]  lo;
  logic signed [SUM_W-1:0] sum;
  logic                    all_one;
  logic                    any_one;
  logic signed [FW-1:0]    sat;

  // coefficient split into a signed upper part and an unsigned low 16 bits
  assign sum     = SUM_W'(hi) + SUM_W'(lo >>> 16);
  assign all_one = &sum[SUM_W-1:FW-1];
  assign any_one = |sum[SUM_W-1:FW-1];

  always_comb begin
    if (all_one || !any_one) begin
      sat = sum[FW-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(FW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(FW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    hi        <= HI_W'(pos) * HI_W'($signed(coef[CW-1:16]));
    lo        <= LO_W'(pos) * LO_W'($signed({1'b0, coef[15:0]}));
    force_out <= sat;
  end

endmodule

// ===== src/wavetable_interp_quadrupole_force.sv =====
// wavetable_interp_quadrupole_force: top level with sequencer, registers and merge stage
// depends on wiqf_pkg, wiqf_wave and wiqf_force_lane
`timescale 1ns / 1ps

// One request is handled at a time. A no-op goes straight to its result, an
// advance runs through phase add, index multiply, two-port table read,
// interpolation multiply and potential update, and a force query through q times
// potential, coefficient stage, lane partial products, lane sum and saturation;
// the x, y and z forces are worked out in three lanes side by side.
// A result waits in the output register while out_stall is high, and a request
// can be accepted during that wait; its own result then waits for the slot. The
// wave table has no reset: every entry must be loaded before an advance reads it.
// Configuration is taken at any time (cfg_ready is always high) and should only
// be written while no request is in flight.
module wavetable_interp_quadrupole_force #(
  parameter int TABLE_DEPTH = wiqf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wiqf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wiqf_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wiqf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wiqf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PW = wiqf_pkg::PTS_W;
  localparam int CW = wiqf_pkg::COEF_W;
  localparam int FW = wiqf_pkg::FORCE_W;

  wiqf_pkg::state_t    state;
  wiqf_pkg::state_t    state_next;
  wiqf_pkg::in_item_t  in_r;
  wiqf_pkg::wave_ctrl_t ctrl;
  wiqf_pkg::out_item_t merged;
  logic                load_out;

  logic [PW-1:0]       points_in_use;
  logic signed [31:0]  q_coef;
  logic signed [31:0]  a_coef;
  logic [PW-1:0]       n_eff;

  logic signed [wiqf_pkg::AMP_W-1:0] potential;
  logic signed [47:0]  pv;
  logic signed [47:0]  npv;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic signed [FW-1:0] fx;
  logic signed [FW-1:0] fy;
  logic signed [FW-1:0] fz;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != wiqf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= wiqf_pkg::POINTS_RESET;
      q_coef        <= '0;
      a_coef        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wiqf_pkg::CFG_POINTS: points_in_use <= cfg_data[PW-1:0];
        wiqf_pkg::CFG_Q:      q_coef        <= $signed(cfg_data);
        wiqf_pkg::CFG_A:      a_coef        <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // zero points counts as one, more than the table holds is clamped to the depth
  always_comb begin
    if (points_in_use == '0) begin
      n_eff = {{(PW-1){1'b0}}, 1'b1};
    end else if (32'(points_in_use) > TABLE_DEPTH) begin
      n_eff = PW'(TABLE_DEPTH);
    end else begin
      n_eff = points_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wiqf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    load_out   = 1'b0;
    case (state)
      wiqf_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.req_type)
            wiqf_pkg::REQ_LOAD:    state_next = wiqf_pkg::ST_LOAD;
            wiqf_pkg::REQ_ADVANCE: state_next = wiqf_pkg::ST_ADV1;
            wiqf_pkg::REQ_FORCE:   state_next = wiqf_pkg::ST_FRC1;
            default:               state_next = wiqf_pkg::ST_DONE;
          endcase
        end
      end
      wiqf_pkg::ST_LOAD: begin
        ctrl.we    = 1'b1;
        state_next = wiqf_pkg::ST_DONE;
      end
      wiqf_pkg::ST_ADV1: begin
        ctrl.phase_en = 1'b1;
        state_next    = wiqf_pkg::ST_ADV2;
      end
      wiqf_pkg::ST_ADV2: state_next = wiqf_pkg::ST_ADV3;
      wiqf_pkg::ST_ADV3: state_next = wiqf_pkg::ST_ADV4;
      wiqf_pkg::ST_ADV4: state_next = wiqf_pkg::ST_ADV5;
      wiqf_pkg::ST_ADV5: begin
        ctrl.pot_en = 1'b1;
        state_next  = wiqf_pkg::ST_DONE;
      end
      wiqf_pkg::ST_FRC1: state_next = wiqf_pkg::ST_FRC2;
      wiqf_pkg::ST_FRC2: state_next = wiqf_pkg::ST_FRC3;
      wiqf_pkg::ST_FRC3: state_next = wiqf_pkg::ST_FRC4;
      wiqf_pkg::ST_FRC4: state_next = wiqf_pkg::ST_DONE;
      wiqf_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = wiqf_pkg::ST_IDLE;
        end
      end
      default: state_next = wiqf_pkg::ST_IDLE;
    endcase
  end

  wiqf_wave #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_wave (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .load_index (in_r.load_index),
    .load_value (in_r.load_value),
    .phase_step (in_r.phase_step),
    .n_eff      (n_eff),
    .potential  (potential)
  );

  // coefficients: 2qV - a, -2qV - a and 2a, all Q.16
  assign npv = -pv;

  always_ff @(posedge clk) begin
    pv <= 48'(q_coef) * 48'(potential);
    cx <= CW'($signed(pv[47:14])) - CW'(a_coef);
    cy <= CW'($signed(npv[47:14])) - CW'(a_coef);
    cz <= CW'(a_coef) + CW'(a_coef);
  end

  wiqf_force_lane u_lane_x (.clk(clk), .pos(in_r.pos_x), .coef(cx), .force_out(fx));
  wiqf_force_lane u_lane_y (.clk(clk), .pos(in_r.pos_y), .coef(cy), .force_out(fy));
  wiqf_force_lane u_lane_z (.clk(clk), .pos(in_r.pos_z), .coef(cz), .force_out(fz));

  // merge lanes into one result, forces only for a force query
  always_comb begin
    merged.potential_now = potential;
    if (in_r.req_type == wiqf_pkg::REQ_FORCE) begin
      merged.force_x = fx;
      merged.force_y = fy;
      merged.force_z = fz;
    end else begin
      merged.force_x = '0;
      merged.force_y = '0;
      merged.force_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= merged;
    end
  end

endmodule

// ===== src/wiqf_checker.sv =====
// wiqf_checker: port-level assertions for the wavetable quadrupole force block
// depends on wiqf_pkg; bound to wavetable_interp_quadrupole_force below
`timescale 1ns / 1ps

module wiqf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wiqf_pkg::out_item_t out_data
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one request at a time, the input is busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // a result only appears at the end of a request
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

  // finishing a request always leaves its result in the output register
  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid)
    else $error("request finished without a result");

endmodule

bind wavetable_interp_quadrupole_force wiqf_checker u_wiqf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/wavetable_interp_quadrupole_force_tb.sv =====
// wavetable_interp_quadrupole_force_tb: self-checking bench for the wavetable force block
// depends on wiqf_pkg and wavetable_interp_quadrupole_force; predicts every result itself
`timescale 1ns / 1ps

module wavetable_interp_quadrupole_force_tb;

  localparam int DEPTH         = wiqf_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 10;

  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic signed [95:0] FORCE_HI = 96'sd140737488355327;
  localparam logic signed [95:0] FORCE_LO = -96'sd140737488355328;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  wiqf_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  wiqf_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [wiqf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wiqf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  always #6 clk = ~clk;

  wavetable_interp_quadrupole_force u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // oscillator state as the block should hold it
  logic [31:0]                       osc_phase  = '0;
  logic signed [wiqf_pkg::AMP_W-1:0] osc_pot    = '0;
  logic signed [wiqf_pkg::AMP_W-1:0] osc_table [DEPTH];
  logic [wiqf_pkg::PTS_W-1:0]        osc_points = wiqf_pkg::POINTS_RESET;
  logic signed [31:0]                osc_q      = '0;
  logic signed [31:0]                osc_a      = '0;

  // request generation runs ahead of the block, so it keeps its own phase
  logic [31:0] gen_phase = '0;
  bit          gen_loaded [DEPTH];

  wiqf_pkg::in_item_t  queued_requests[$];
  wiqf_pkg::out_item_t predicted_forces[$];

  bit req_taken = 1'b0;
  bit hold_go   = 1'b0;
  bit sink_hold = 1'b0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int cycle_count   = 0;

  int n_errors = 0, n_checked = 0, n_clipped = 0;
  int n_loads = 0, n_advances = 0, n_forces = 0, n_noops = 0;

  function automatic int eff_points(logic [wiqf_pkg::PTS_W-1:0] p);
    if (p == 0) return 1;
    if (p > DEPTH) return DEPTH;
    return int'(p);
  endfunction

  // table slots and interpolation fraction for a given phase
  function automatic void locate(input logic [31:0] ph, input int n, output int i1,
                                 output int i2, output longint fr);
    logic [63:0] prod;
    prod = {32'd0, ph} * 64'(n);
    i1   = int'(prod[63:32]);
    i2   = (i1 + 1 >= n) ? 0 : i1 + 1;
    fr   = longint'(prod[31:0]);
  endfunction

  function automatic logic signed [wiqf_pkg::FORCE_W-1:0] scaled_force(
      input longint pos, input longint coef, output bit clipped);
    logic signed [95:0] wide_pos, wide_coef, prod;
    wide_pos  = pos;
    wide_coef = coef;
    prod      = (wide_pos * wide_coef) >>> 16;
    clipped   = (prod > FORCE_HI) || (prod < FORCE_LO);
    if (prod > FORCE_HI) prod = FORCE_HI;
    else if (prod < FORCE_LO) prod = FORCE_LO;
    return prod[wiqf_pkg::FORCE_W-1:0];
  endfunction

  function automatic wiqf_pkg::out_item_t step_oscillator(wiqf_pkg::in_item_t req);
    wiqf_pkg::out_item_t res;
    int        i1, i2;
    longint    fr, diff, qv, cx, cy, cz;
    bit        c0, c1, c2;
    res = '0;
    case (req.req_type)
      wiqf_pkg::REQ_LOAD: begin
        osc_table[req.load_index] = req.load_value;
        n_loads++;
      end
      wiqf_pkg::REQ_ADVANCE: begin
        osc_phase = osc_phase + req.phase_step;
        locate(osc_phase, eff_points(osc_points), i1, i2, fr);
        diff    = longint'(osc_table[i2]) - longint'(osc_table[i1]);
        osc_pot = 16'(longint'(osc_table[i1]) + ((diff * fr) >>> 32));
        n_advances++;
      end
      wiqf_pkg::REQ_FORCE: begin
        qv = longint'(osc_q) * longint'(osc_pot);
        cx = (qv >>> 14) - longint'(osc_a);
        cy = ((-qv) >>> 14) - longint'(osc_a);
        cz = 2 * longint'(osc_a);
        res.force_x = scaled_force(longint'(req.pos_x), cx, c0);
        res.force_y = scaled_force(longint'(req.pos_y), cy, c1);
        res.force_z = scaled_force(longint'(req.pos_z), cz, c2);
        n_clipped += int'(c0) + int'(c1) + int'(c2);
        n_forces++;
      end
      default: begin
        n_noops++;
      end
    endcase
    res.potential_now = osc_pot;
    return res;
  endfunction

  function automatic wiqf_pkg::in_item_t random_item();
    wiqf_pkg::in_item_t it;
    it.req_type   = 2'($urandom);
    it.load_index = 10'($urandom);
    it.load_value = 16'($urandom);
    it.phase_step = $urandom;
    it.pos_x      = $urandom;
    it.pos_y      = $urandom;
    it.pos_z      = $urandom;
    return it;
  endfunction

  function automatic logic [wiqf_pkg::AMP_W-1:0] rand_amp();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(32'h3ffff)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void enqueue_request(wiqf_pkg::in_item_t it);
    queued_requests = {queued_requests, it};
  endfunction

  function automatic void push_load(logic [9:0] idx, logic [wiqf_pkg::AMP_W-1:0] val);
    wiqf_pkg::in_item_t it;
    it            = random_item();
    it.req_type   = wiqf_pkg::REQ_LOAD;
    it.load_index = idx;
    it.load_value = val;
    gen_loaded[idx] = 1'b1;
    enqueue_request(it);
  endfunction

  // fills both table slots that the advance will read before sending it
  function automatic void push_advance(logic [31:0] step);
    wiqf_pkg::in_item_t it;
    int       i1, i2;
    longint   fr;
    gen_phase = gen_phase + step;
    locate(gen_phase, eff_points(osc_points), i1, i2, fr);
    if (!gen_loaded[i1]) push_load(10'(i1), rand_amp());
    if (!gen_loaded[i2]) push_load(10'(i2), rand_amp());
    it            = random_item();
    it.req_type   = wiqf_pkg::REQ_ADVANCE;
    it.phase_step = step;
    enqueue_request(it);
  endfunction

  function automatic void push_force(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    wiqf_pkg::in_item_t it;
    it          = random_item();
    it.req_type = wiqf_pkg::REQ_FORCE;
    it.pos_x    = x;
    it.pos_y    = y;
    it.pos_z    = z;
    enqueue_request(it);
  endfunction

  function automatic void push_noop();
    wiqf_pkg::in_item_t it;
    it          = random_item();
    it.req_type = REQ_NOP;
    enqueue_request(it);
  endfunction

  function automatic void push_random();
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      if ($urandom_range(3) != 0)
        push_load(10'($urandom_range(eff_points(osc_points) - 1)), rand_amp());
      else
        push_load(10'($urandom), rand_amp());
    end else if (r < 60) begin
      push_advance(rand_step());
    end else if (r < 95) begin
      push_force(rand_pos(), rand_pos(), rand_pos());
    end else begin
      push_noop();
    end
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [wiqf_pkg::FORCE_W-1:0] got,
                                 input logic [wiqf_pkg::FORCE_W-1:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic write_reg(input logic [wiqf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wiqf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wiqf_pkg::CFG_POINTS: osc_points = val[wiqf_pkg::PTS_W-1:0];
      wiqf_pkg::CFG_Q:      osc_q      = val;
      wiqf_pkg::CFG_A:      osc_a      = val;
      default:              ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] pts, input logic [31:0] q, input logic [31:0] a);
    write_reg(wiqf_pkg::CFG_POINTS, pts);
    write_reg(wiqf_pkg::CFG_Q, q);
    write_reg(wiqf_pkg::CFG_A, a);
  endtask

  task automatic drain();
    while (queued_requests.size() != 0 || in_valid || predicted_forces.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] pts, input logic [31:0] q, input logic [31:0] a,
                           input int src_pct, input int sink_pct, input int count);
    set_config(pts, q, a);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) push_random();
    drain();
  endtask

  // request side
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (queued_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_data  <= queued_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predicted_forces = {predicted_forces, step_oscillator(in_data)};
      req_taken = 1'b1;
    end
  end

  // result side
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= sink_hold || ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    wiqf_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (predicted_forces.size() == 0) begin
        report_mismatch("unrequested result", 48'(out_data.potential_now), '0);
      end else begin
        want = predicted_forces.pop_front();
        if (out_data.potential_now !== want.potential_now)
          report_mismatch("potential", 48'(out_data.potential_now), 48'(want.potential_now));
        if (out_data.force_x !== want.force_x)
          report_mismatch("force_x", out_data.force_x, want.force_x);
        if (out_data.force_y !== want.force_y)
          report_mismatch("force_y", out_data.force_y, want.force_y);
        if (out_data.force_z !== want.force_z)
          report_mismatch("force_z", out_data.force_z, want.force_z);
      end
    end
  end

  // long output hold so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    sink_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    sink_hold = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // four points, q of one, a of one half
    set_config(32'd4, 32'h0001_0000, 32'h0000_8000);
    src_idle_pct  = 19;
    sink_idle_pct = 58;
    push_force(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    push_noop();
    push_load(10'd0, 16'h7fff);
    push_load(10'd1, 16'h8000);
    push_load(10'd2, 16'h0000);
    push_load(10'd3, 16'h5a5a);
    push_load(10'd1023, 16'hffff);
    push_advance(32'd0);
    push_force(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
    // a load leaves the potential alone until the next advance
    push_load(10'd0, 16'h0001);
    push_advance(32'h4000_0000);
    push_advance(32'h2000_0000);
    push_force(32'h0002_0000, 32'h0003_0000, 32'hfffe_0000);
    // lands on the last point, so the upper neighbour wraps to entry zero
    push_advance(32'h6000_0000);
    push_advance(32'hffff_ffff);
    push_force(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_noop();
    repeat (260) push_random();
    drain();

    hold_go = 1'b1;
    run_phase({21'($urandom), 11'd1}, $urandom, $urandom, 19, 58, 325);
    run_phase(32'd0, 32'h7fff_ffff, 32'h8000_0000, 58, 19, 325);
    run_phase(32'd2047, 32'h8000_0000, 32'h7fff_ffff, 58, 19, 325);
    run_phase(32'd1024, 32'($urandom_range(32'h7ffff)) - 32'h40000,
              32'($urandom_range(32'hfffff)) - 32'h80000, 0, 0, 325);
    run_phase(32'($urandom_range(1023, 2)), $urandom, $urandom, 0, 0, 325);

    $display("requests: %0d loads, %0d advances, %0d force queries, %0d no-ops",
             n_loads, n_advances, n_forces, n_noops);
    $display("%0d results checked over six register settings, %0d force components clipped",
             n_checked, n_clipped);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wiqf_pkg.sv
src/wiqf_wave.sv
src/wiqf_force_lane.sv
src/wavetable_interp_quadrupole_force.sv
src/wiqf_checker.sv
test/wavetable_interp_quadrupole_force_tb.sv
